@@ src/psts_pkg.sv @@
package psts_pkg;

	localparam int TableEntriesDefault = 64;
	localparam int SymW   = 32;
	localparam int TimeW  = 48;
	localparam int VolW   = 20;
	localparam int PriceW = 20;
	localparam int VSumW  = 32;
	localparam int WSumW  = 52;
	localparam int QueueDepth = 2;

	typedef struct packed {
		logic [SymW-1:0]   symbol_code;
		logic [TimeW-1:0]  trade_time;
		logic [VolW-1:0]   trade_volume;
		logic [PriceW-1:0] trade_price;
	} trade_t;

	typedef struct packed {
		logic              table_full;
		logic              is_new_symbol;
		logic [TimeW-1:0]  largest_gap;
		logic [VSumW-1:0]  volume_total;
		logic [PriceW-1:0] average_price;
		logic [PriceW-1:0] highest_price;
		logic              total_overflow;
	} stats_t;

endpackage

@@ src/per_symbol_trade_stats.sv @@
// Per-symbol trade statistics. Each request on s_axis carries one trade and
// produces exactly one result on m_axis. The back end searches the entry table
// one entry at a time, reading and then checking each, and for a known symbol
// whose volume total is not zero runs a 52-step bit-serial divider for the
// weighted average. A new symbol takes a free entry, and a trade for a new
// symbol is dropped while the table is full. The result is held on m_axis
// until m_axis_tready. A two-deep queue decouples input.
module per_symbol_trade_stats #(
	parameter int TABLE_ENTRIES = psts_pkg::TableEntriesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// symbol_code[31:0], trade_time[79:32], trade_volume[99:80], trade_price[119:100]
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// table_full, is_new_symbol, largest_gap[49:2], volume_total[81:50],
	// average_price[101:82], highest_price[121:102], total_overflow[122]
	output logic [127:0] m_axis_tdata
);

	psts_pkg::trade_t in_trade;
	psts_pkg::trade_t q_trade;
	psts_pkg::stats_t st;
	logic             q_valid;
	logic             q_ready;

	assign in_trade.symbol_code  = s_axis_tdata[31:0];
	assign in_trade.trade_time   = s_axis_tdata[79:32];
	assign in_trade.trade_volume = s_axis_tdata[99:80];
	assign in_trade.trade_price  = s_axis_tdata[119:100];

	assign m_axis_tdata = {5'd0, st.total_overflow, st.highest_price, st.average_price,
		st.volume_total, st.largest_gap, st.is_new_symbol, st.table_full};

	psts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_trade (in_trade),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_trade  (q_trade)
	);

	psts_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_trade   (q_trade),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_stats (st)
	);

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st.table_full |-> !st.is_new_symbol && st.volume_total == '0)
		else $error("dropped trade carries stats");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(st.table_full && st.total_overflow))
		else $error("full and overflow together");

endmodule

@@ src/psts_front.sv @@
module psts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psts_pkg::trade_t    in_trade,
	output logic                q_valid,
	input  logic                q_ready,
	output psts_pkg::trade_t    q_trade
);

	localparam int Depth = psts_pkg::QueueDepth;

	psts_pkg::trade_t mem_q [Depth];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign in_ready = (cnt_q != 2'(Depth));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_trade  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mem_q[wr_q] <= in_trade;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wr_q <= ~wr_q;
			end
			if (q_valid && q_ready) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

endmodule

@@ src/psts_div.sv @@
module psts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [psts_pkg::WSumW-1:0]     dividend,
	input  logic [psts_pkg::VSumW-1:0]     divisor,
	output logic                           done,
	output logic [psts_pkg::PriceW-1:0]    quotient
);

	localparam int NW = psts_pkg::WSumW;
	localparam int DW = psts_pkg::VSumW;

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] dsr_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted  = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial    = shifted - {1'b0, dsr_q};
	assign quotient = (quo_q[NW-1:psts_pkg::PriceW] != '0) ? '1 : quo_q[psts_pkg::PriceW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

@@ src/psts_back.sv @@
module psts_back #(
	parameter int TABLE_ENTRIES = psts_pkg::TableEntriesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  psts_pkg::trade_t    q_trade,
	output logic                out_valid,
	input  logic                out_ready,
	output psts_pkg::stats_t    out_stats
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_READ   = 7'b0000010,
		ST_CHECK  = 7'b0000100,
		ST_UPDATE = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_WRITE  = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [psts_pkg::SymW-1:0]   sym_mem   [TABLE_ENTRIES];
	logic [psts_pkg::TimeW-1:0]  time_mem  [TABLE_ENTRIES];
	logic [psts_pkg::TimeW-1:0]  gap_mem   [TABLE_ENTRIES];
	logic [psts_pkg::VSumW-1:0]  vol_mem   [TABLE_ENTRIES];
	logic [psts_pkg::WSumW-1:0]  wsum_mem  [TABLE_ENTRIES];
	logic [psts_pkg::PriceW-1:0] pmax_mem  [TABLE_ENTRIES];
	logic [psts_pkg::PriceW-1:0] avg_mem   [TABLE_ENTRIES];

	psts_pkg::trade_t            trade_q;
	logic [CW-1:0]               used_q;
	logic [CW-1:0]               idx_q;
	logic [psts_pkg::SymW-1:0]   rsym_q;
	logic [psts_pkg::TimeW-1:0]  rtime_q;
	logic [psts_pkg::TimeW-1:0]  gap_q;
	logic [psts_pkg::VSumW-1:0]  vol_q;
	logic [psts_pkg::WSumW-1:0]  wsum_q;
	logic [psts_pkg::PriceW-1:0] pmax_q;
	logic [psts_pkg::PriceW-1:0] avg_q;
	logic [39:0]                 prod_q;
	psts_pkg::stats_t            res_q;

	logic [psts_pkg::TimeW-1:0]  gap_new;
	logic [psts_pkg::VSumW:0]    vol_add;
	logic [psts_pkg::WSumW:0]    wsum_add;
	logic [psts_pkg::VSumW-1:0]  vol_nxt;
	logic [psts_pkg::WSumW-1:0]  wsum_nxt;
	logic                        div_done;
	logic [psts_pkg::PriceW-1:0] div_quo;
	logic                        div_start;

	assign q_ready   = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_stats = res_q;
	assign gap_new   = trade_q.trade_time - rtime_q;
	assign vol_add   = {1'b0, vol_q} + 33'(trade_q.trade_volume);
	assign wsum_add  = {1'b0, wsum_q} + 53'(prod_q);
	assign vol_nxt   = vol_add[psts_pkg::VSumW] ? '1 : vol_add[psts_pkg::VSumW-1:0];
	assign wsum_nxt  = wsum_add[psts_pkg::WSumW] ? '1 : wsum_add[psts_pkg::WSumW-1:0];
	assign div_start = (state_q == ST_UPDATE) && (vol_nxt != '0);

	psts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum_nxt),
		.divisor  (vol_nxt),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			trade_q <= q_trade;
			prod_q  <= 40'(q_trade.trade_volume) * 40'(q_trade.trade_price);
		end
		if (state_q == ST_READ) begin
			rsym_q  <= sym_mem[idx_q[IW-1:0]];
			rtime_q <= time_mem[idx_q[IW-1:0]];
			gap_q   <= gap_mem[idx_q[IW-1:0]];
			vol_q   <= vol_mem[idx_q[IW-1:0]];
			wsum_q  <= wsum_mem[idx_q[IW-1:0]];
			pmax_q  <= pmax_mem[idx_q[IW-1:0]];
			avg_q   <= avg_mem[idx_q[IW-1:0]];
		end
		if (state_q == ST_CHECK && idx_q == used_q) begin
			gap_q  <= '0;
			vol_q  <= 32'(trade_q.trade_volume);
			wsum_q <= 52'(prod_q);
			pmax_q <= trade_q.trade_price;
			avg_q  <= trade_q.trade_price;
		end
		if (state_q == ST_UPDATE) begin
			if (idx_q != used_q) begin
				if (gap_new > gap_q) gap_q <= gap_new;
				vol_q  <= vol_nxt;
				wsum_q <= wsum_nxt;
				if (trade_q.trade_price > pmax_q) pmax_q <= trade_q.trade_price;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			avg_q <= div_quo;
		end
		if (state_q == ST_WRITE) begin
			sym_mem[idx_q[IW-1:0]]  <= trade_q.symbol_code;
			time_mem[idx_q[IW-1:0]] <= trade_q.trade_time;
			gap_mem[idx_q[IW-1:0]]  <= gap_q;
			vol_mem[idx_q[IW-1:0]]  <= vol_q;
			wsum_mem[idx_q[IW-1:0]] <= wsum_q;
			pmax_mem[idx_q[IW-1:0]] <= pmax_q;
			avg_mem[idx_q[IW-1:0]]  <= avg_q;
			res_q.table_full     <= 1'b0;
			res_q.is_new_symbol  <= (idx_q == used_q);
			res_q.largest_gap    <= gap_q;
			res_q.volume_total   <= vol_q;
			res_q.average_price  <= avg_q;
			res_q.highest_price  <= pmax_q;
			res_q.total_overflow <= (vol_q == '1) || (wsum_q == '1);
		end
		if (state_q == ST_CHECK && idx_q == used_q && used_q == CW'(TABLE_ENTRIES)) begin
			res_q <= {1'b1, {($bits(psts_pkg::stats_t) - 1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						idx_q   <= '0;
						state_q <= (used_q == '0) ? ST_CHECK : ST_READ;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (idx_q == used_q) begin
						if (used_q == CW'(TABLE_ENTRIES)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_WRITE;
						end
					end else if (rsym_q == trade_q.symbol_code) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == used_q) ? ST_CHECK : ST_READ;
					end
				end
				ST_UPDATE: state_q <= ST_DIV;
				ST_DIV: begin
					if (vol_q == '0 || div_done) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (idx_q == used_q) used_q <= used_q + CW'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ test/tb_per_symbol_trade_stats.sv @@
module tb_per_symbol_trade_stats;

	localparam int Entries = psts_pkg::TableEntriesDefault;
	localparam longint CycleLimit = 2000000;
	localparam logic [31:0] Vol32Max = 32'hFFFF_FFFF;
	localparam logic [51:0] WSum52Max = 52'hF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        full;
		logic        fresh;
		logic [47:0] gap;
		logic [31:0] vol;
		logic [19:0] avg;
		logic [19:0] hi;
		logic        ovf;
	} trade_stats_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;

	logic [31:0] sym_key   [Entries];
	logic [47:0] prev_time [Entries];
	logic [47:0] gap_peak  [Entries];
	logic [31:0] vol_total [Entries];
	logic [51:0] wsum      [Entries];
	logic [19:0] price_peak[Entries];
	logic [19:0] vwap      [Entries];
	int          entries_used;

	trade_stats_t stats_due[$];
	int           error_count;
	longint       cycle_count;
	bit           quiet;
	int           drain_cycles;

	per_symbol_trade_stats i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic trade_stats_t predict_trade(logic [31:0] sym, logic [47:0] t,
			logic [19:0] v, logic [19:0] p);
		trade_stats_t r;
		int          hit;
		logic [47:0] g;
		logic [32:0] vs;
		logic [52:0] ws;
		logic [51:0] q;
		hit = -1;
		r = '0;
		for (int i = 0; i < entries_used; i++)
			if (hit < 0 && sym_key[i] == sym)
				hit = i;
		if (hit < 0) begin
			if (entries_used >= Entries) begin
				r.full = 1'b1;
				return r;
			end
			hit = entries_used;
			entries_used++;
			sym_key[hit] = sym;
			prev_time[hit] = t;
			gap_peak[hit] = '0;
			vol_total[hit] = 32'(v);
			wsum[hit] = 52'(v) * 52'(p);
			price_peak[hit] = p;
			vwap[hit] = p;
			r.fresh = 1'b1;
		end else begin
			g = t - prev_time[hit];
			if (g > gap_peak[hit])
				gap_peak[hit] = g;
			prev_time[hit] = t;
			vs = 33'(vol_total[hit]) + 33'(v);
			vol_total[hit] = vs[32] ? Vol32Max : vs[31:0];
			ws = 53'(wsum[hit]) + 53'(v) * 53'(p);
			wsum[hit] = ws[52] ? WSum52Max : ws[51:0];
			if (p > price_peak[hit])
				price_peak[hit] = p;
			if (vol_total[hit] != 0) begin
				q = wsum[hit] / 52'(vol_total[hit]);
				vwap[hit] = (q > 52'hF_FFFF) ? 20'hF_FFFF : q[19:0];
			end
		end
		r.gap = gap_peak[hit];
		r.vol = vol_total[hit];
		r.avg = vwap[hit];
		r.hi = price_peak[hit];
		r.ovf = (vol_total[hit] == Vol32Max) || (wsum[hit] == WSum52Max);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	task automatic send_trade(logic [31:0] sym, logic [47:0] t, logic [19:0] v, logic [19:0] p);
		while (!quiet && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p, v, t, sym};
		stats_due.push_back(predict_trade(sym, t, v, p));
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	always @(posedge clk) begin
		trade_stats_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.full = m_axis_tdata[0];
				got.fresh = m_axis_tdata[1];
				got.gap = m_axis_tdata[49:2];
				got.vol = m_axis_tdata[81:50];
				got.avg = m_axis_tdata[101:82];
				got.hi = m_axis_tdata[121:102];
				got.ovf = m_axis_tdata[122];
				if (stats_due.size() == 0) begin
					report_mismatch("unexpected request", 64'(got.vol), 64'd0);
				end else begin
					want = stats_due.pop_front();
					if (got.full != want.full)
						report_mismatch("table_full", 64'(got.full), 64'(want.full));
					if (got.fresh != want.fresh)
						report_mismatch("is_new_symbol", 64'(got.fresh), 64'(want.fresh));
					if (got.gap != want.gap)
						report_mismatch("largest_gap", 64'(got.gap), 64'(want.gap));
					if (got.vol != want.vol)
						report_mismatch("volume_total", 64'(got.vol), 64'(want.vol));
					if (got.avg != want.avg)
						report_mismatch("average_price", 64'(got.avg), 64'(want.avg));
					if (got.hi != want.hi)
						report_mismatch("highest_price", 64'(got.hi), 64'(want.hi));
					if (got.ovf != want.ovf)
						report_mismatch("total_overflow", 64'(got.ovf), 64'(want.ovf));
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [31:0] pick_symbol(int pool);
		return {8'h41 + 8'($urandom_range(pool - 1)), 8'h58, 16'h0000};
	endfunction

	task automatic test_directed();
		send_trade(32'h0000_0000, 48'h0, 20'h0, 20'h0);
		send_trade(32'h0000_0000, 48'hFFFF_FFFF_FFFF, 20'h0, 20'hF_FFFF);
		send_trade(32'h0000_0000, 48'h5, 20'h0, 20'h1);
		send_trade(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 20'hF_FFFF, 20'hF_FFFF);
		send_trade(32'hFFFF_FFFF, 48'h0, 20'h1, 20'h0);
		send_trade(32'h4142_4344, 48'h10, 20'h3, 20'h7);
		send_trade(32'h4142_4344, 48'h20, 20'h5, 20'h2);
		send_trade(32'h4142_4344, 48'h18, 20'h0, 20'hA);
	endtask

	task automatic test_saturation();
		send_trade(32'h5341_5400, 48'h1, 20'hF_FFFF, 20'hF_FFFF);
		for (int i = 0; i < 40; i++) begin
			quiet = (i > 10);
			send_trade(32'h5341_5400, 48'(i + 2), 20'hF_FFFF, 20'(i[0] ? 20'hF_FFFF : 20'h1));
		end
		quiet = 1'b0;
		send_trade(32'h5341_5400, 48'h0, 20'h0, 20'h0);
	endtask

	task automatic test_random(int count, int pool);
		logic [47:0] t;
		for (int i = 0; i < count; i++) begin
			t = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
				48'(i) * 48'd1000 + 48'($urandom_range(999));
			quiet = (i >= count / 2) && (i < count / 2 + 80);
			send_trade(($urandom_range(19) == 0) ? $urandom : pick_symbol(pool), t,
				($urandom_range(9) == 0) ? 20'hF_FFFF : 20'($urandom),
				20'($urandom));
		end
		quiet = 1'b0;
	endtask

	task automatic test_table_full();
		while (entries_used < Entries)
			send_trade($urandom, 48'({$urandom, $urandom}), 20'($urandom), 20'($urandom));
		for (int i = 0; i < 20; i++)
			send_trade(($urandom_range(1) == 0) ? $urandom : pick_symbol(6),
				48'({$urandom, $urandom}), 20'($urandom), 20'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		entries_used = 0;
		quiet = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_random(600, 12);
		test_table_full();
		test_random(120, 26);
		s_axis_tvalid <= 1'b0;
		while (stats_due.size() != 0)
			@(posedge clk);
		drain_cycles = 0;
		while (drain_cycles < 400) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
